>>> rtl/wfd_pkg.sv
// Package for the WebSocket frame deframer: widths, opcodes and frame kinds.
// Used by websocket_frame_deframer_top; depends on nothing else.
package wfd_pkg;

  // Width of the payload length and remaining-byte counter (16 to 64)
  localparam int unsigned LenBits = 64;

  // Frame header fields
  localparam logic [3:0] OpText   = 4'h1;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [3:0] OpClose  = 4'h8;
  localparam logic [3:0] OpPing   = 4'h9;
  localparam logic [3:0] OpPong   = 4'hA;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  // Output frame kinds
  localparam logic [2:0] KindText   = 3'd0;
  localparam logic [2:0] KindBinary = 3'd1;
  localparam logic [2:0] KindClose  = 3'd2;
  localparam logic [2:0] KindPing   = 3'd3;
  localparam logic [2:0] KindPong   = 3'd4;

  // True for an opcode that carries a supported frame kind
  function automatic logic op_known(input logic [3:0] op);
    logic ok;
    begin
      case (op)
        OpText, OpBinary, OpClose, OpPing, OpPong: ok = 1'b1;
        default:                                   ok = 1'b0;
      endcase
      return ok;
    end
  endfunction

  // Map an opcode to its frame kind; unknown opcodes map to text
  function automatic logic [2:0] kind_of(input logic [3:0] op);
    logic [2:0] k;
    begin
      case (op)
        OpText:   k = KindText;
        OpBinary: k = KindBinary;
        OpClose:  k = KindClose;
        OpPing:   k = KindPing;
        OpPong:   k = KindPong;
        default:  k = KindText;
      endcase
      return k;
    end
  endfunction

endpackage

>>> rtl/websocket_frame_deframer_top.sv
// WebSocket frame deframer: header parse, key capture, payload unmasking.
// A word's result is loaded into the output register by the clock edge that accepts the word.
// Throughput: one byte per cycle; in_ready_o is low only while a result waits to be taken.
// The parser state and the result register update in the same edge; a 64-bit
// remaining-byte down-counter sets the longest path.
// Reset (rst_ni low, asynchronous) returns to the first header byte with no result pending.
// Depends on wfd_pkg.
module websocket_frame_deframer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       segment_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] frame_kind_o,
  output logic [7:0] payload_byte_o,
  output logic       byte_valid_o,
  output logic       final_fragment_o,
  output logic       frame_last_o,
  output logic       truncated_o
);
  import wfd_pkg::*;

  typedef enum logic [2:0] {
    PhHdr0,
    PhHdr1,
    PhExt,
    PhKey,
    PhData
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [2:0]           kind_q, kind_d;
  logic                 fin_q, fin_d;
  logic                 mask_q, mask_d;
  logic [2:0]           cnt_q, cnt_d;
  logic [LenBits-1:0]   len_q, len_d;
  logic [31:0]          key_q, key_d;
  logic [1:0]           idx_q, idx_d;
  logic                 disc_q, disc_d;

  logic                 out_valid_q;
  logic [2:0]           kind_out_q;
  logic [7:0]           byte_out_q;
  logic                 bval_out_q, fin_out_q, last_out_q, trunc_out_q;

  logic                 accept;
  logic                 res_v, res_bval, res_last, res_trunc;
  logic [7:0]           res_byte;
  logic                 hdr_done, start_pl;
  logic [6:0]           len7;
  logic [7:0]           key_byte;

  // Take a new word whenever the result register is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign len7       = rx_byte_i[6:0];

  // Pick the key byte for the current payload index, first key byte on top
  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Parse one word: advance the phase, collect length and key, unmask data
  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    fin_d     = fin_q;
    mask_d    = mask_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    key_d     = key_q;
    idx_d     = idx_q;
    disc_d    = disc_q;
    res_v     = 1'b0;
    res_byte  = 8'h00;
    res_bval  = 1'b0;
    res_last  = 1'b0;
    res_trunc = 1'b0;
    hdr_done  = 1'b0;
    start_pl  = 1'b0;

    if (!disc_q) begin
      unique case (phase_q)
        PhHdr0: begin
          fin_d  = rx_byte_i[7];
          kind_d = kind_of(rx_byte_i[3:0]);
          mask_d = 1'b0;
          cnt_d  = 3'd0;
          len_d  = '0;
          key_d  = 32'h0;
          idx_d  = 2'd0;
          if (op_known(rx_byte_i[3:0])) begin
            phase_d = PhHdr1;
          end else begin
            disc_d = 1'b1;
          end
        end
        PhHdr1: begin
          mask_d = rx_byte_i[7];
          len_d  = '0;
          if (len7 == Len16Code) begin
            cnt_d   = 3'd1;
            phase_d = PhExt;
          end else if (len7 == Len64Code) begin
            cnt_d   = 3'd7;
            phase_d = PhExt;
          end else begin
            len_d    = LenBits'(len7);
            hdr_done = 1'b1;
          end
        end
        PhExt: begin
          // Saturate a length that would overflow the counter
          if (len_q[LenBits-1 -: 8] != 8'h00) begin
            len_d = '1;
          end else begin
            len_d = {len_q[LenBits-9:0], rx_byte_i};
          end
          if (cnt_q == 3'd0) begin
            hdr_done = 1'b1;
          end else begin
            cnt_d = cnt_q - 3'd1;
          end
        end
        PhKey: begin
          key_d = {key_q[23:0], rx_byte_i};
          if (cnt_q == 3'd0) begin
            start_pl = 1'b1;
          end else begin
            cnt_d = cnt_q - 3'd1;
          end
        end
        PhData: begin
          len_d    = len_q - LenBits'(1);
          idx_d    = idx_q + 2'd1;
          res_v    = 1'b1;
          res_bval = 1'b1;
          res_byte = mask_q ? (rx_byte_i ^ key_byte) : rx_byte_i;
          if (len_q <= LenBits'(1)) begin
            res_last = 1'b1;
            disc_d   = 1'b1;
          end
        end
        default: begin
          phase_d = PhHdr0;
          disc_d  = 1'b1;
        end
      endcase
    end

    // Header complete: fetch the key, or go straight to the payload
    if (hdr_done) begin
      if (mask_d) begin
        phase_d = PhKey;
        cnt_d   = 3'd3;
      end else begin
        start_pl = 1'b1;
      end
    end

    // Enter the payload; an empty frame finishes at once
    if (start_pl) begin
      phase_d = PhData;
      idx_d   = 2'd0;
      if (len_d == '0) begin
        res_v    = 1'b1;
        res_last = 1'b1;
        disc_d   = 1'b1;
      end
    end

    // Segment end: flag an unfinished frame, restart at the header
    if (segment_end_i) begin
      if (!disc_d && phase_d != PhHdr0) begin
        res_v     = 1'b1;
        res_last  = 1'b1;
        res_trunc = 1'b1;
      end
      phase_d = PhHdr0;
      disc_d  = 1'b0;
    end
  end

  // Hold parser state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHdr0;
      kind_q      <= KindText;
      fin_q       <= 1'b0;
      mask_q      <= 1'b0;
      cnt_q       <= 3'd0;
      len_q       <= '0;
      key_q       <= 32'h0;
      idx_q       <= 2'd0;
      disc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        fin_q   <= fin_d;
        mask_q  <= mask_d;
        cnt_q   <= cnt_d;
        len_q   <= len_d;
        key_q   <= key_d;
        idx_q   <= idx_d;
        disc_q  <= disc_d;
      end
      if (accept) begin
        out_valid_q <= res_v;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load result payload with each accepted word that produces one
  always_ff @(posedge clk_i) begin
    if (accept && res_v) begin
      kind_out_q  <= kind_d;
      byte_out_q  <= res_byte;
      bval_out_q  <= res_bval;
      fin_out_q   <= fin_d;
      last_out_q  <= res_last;
      trunc_out_q <= res_trunc;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_kind_o     = kind_out_q;
  assign payload_byte_o   = byte_out_q;
  assign byte_valid_o     = bval_out_q;
  assign final_fragment_o = fin_out_q;
  assign frame_last_o     = last_out_q;
  assign truncated_o      = trunc_out_q;

  // A truncated result always closes its frame
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> frame_last_o)
    else $error("truncated result without frame_last");

  // An empty result carries a zero byte and closes its frame
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> payload_byte_o == 8'h00 && frame_last_o)
    else $error("empty result with data or not last");

  // The remaining count never reaches zero while payload is expected
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData && !disc_q |-> len_q != '0)
    else $error("payload phase with zero remaining length");

  // After a segment end is taken, parsing restarts at the header
  a_seg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && segment_end_i |=> phase_q == PhHdr0 && !disc_q)
    else $error("segment end did not restart parser");

endmodule
